// ===== design/dcgp_pkg.sv =====
// Divided clock gate pulser: shared types and constants.
// No dependencies; imported by every module of the block.
package dcgp_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsW     = 16;
  localparam int unsigned ShiftW  = 3;
  localparam int unsigned CountW  = 5;
  localparam int unsigned WaitW   = MsW + 1;
  localparam int unsigned AddrW   = 2;
  localparam int unsigned OutW    = 8;

  localparam logic [ShiftW-1:0] MaxShift    = 3'd4;
  localparam logic [ShiftW-1:0] OffsetShift = 3'd3;

  typedef enum logic [AddrW-1:0] {
    REG_DIVIDE_SHIFT = 2'd0,
    REG_BASE_PERIOD  = 2'd1,
    REG_HIGH_DELAY   = 2'd2,
    REG_LOW_DELAY    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [ShiftW-1:0] divide_shift;
    logic [MsW-1:0]    base_period_ms;
    logic [MsW-1:0]    high_phase_delay_ms;
    logic [MsW-1:0]    low_phase_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic              phase_high;
    logic              clock_reg;
    logic [CountW-1:0] rise_count;
    logic [CountW-1:0] fall_count;
  } status_t;

  typedef struct packed {
    logic gate_level;
    logic clock_level;
    logic edge_fired;
  } result_t;

endpackage

// ===== design/dcgp_cfg.sv =====
// Configuration register file of the divided clock gate pulser.
// Depends on dcgp_pkg.
module dcgp_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dcgp_pkg::AddrW-1:0]  cfg_addr,
  input  logic [dcgp_pkg::MsW-1:0]    cfg_wdata,
  output dcgp_pkg::cfg_t              cfg
);
  import dcgp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.divide_shift        <= '0;
      cfg.base_period_ms      <= MsW'(250);
      cfg.high_phase_delay_ms <= '0;
      cfg.low_phase_delay_ms  <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_DIVIDE_SHIFT: cfg.divide_shift        <= cfg_wdata[ShiftW-1:0];
        REG_BASE_PERIOD:  cfg.base_period_ms      <= cfg_wdata;
        REG_HIGH_DELAY:   cfg.high_phase_delay_ms <= cfg_wdata;
        REG_LOW_DELAY:    cfg.low_phase_delay_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/dcgp_step.sv =====
// Per-tick wait compare, gate toggle and clock divider state.
// Depends on dcgp_pkg; state advances only when step is high.
module dcgp_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [dcgp_pkg::TimeW-1:0]  now_ms,
  input  dcgp_pkg::cfg_t              cfg,
  output dcgp_pkg::result_t           result,
  output dcgp_pkg::status_t           status
);
  import dcgp_pkg::*;

  logic [TimeW-1:0]  last_edge_time, last_edge_time_next;
  logic              phase_high, phase_high_next;
  logic [MsW-1:0]    pending_delay, pending_delay_next;
  logic [CountW-1:0] rise_count, rise_count_next;
  logic [CountW-1:0] fall_count, fall_count_next;
  logic              clock_reg, clock_reg_next;

  logic [ShiftW-1:0] shift;
  logic [CountW-1:0] target;
  logic [WaitW-1:0]  wait_sum;
  logic [WaitW-1:0]  wait_ms;
  logic [TimeW-1:0]  elapsed;
  logic              fired;
  logic [CountW-1:0] rise_inc, fall_inc;

  always_comb begin
    shift    = (cfg.divide_shift > MaxShift) ? MaxShift : cfg.divide_shift;
    target   = CountW'(1) << shift;
    wait_sum = WaitW'(cfg.base_period_ms) + WaitW'(pending_delay);
    wait_ms  = (wait_sum >> shift) + WaitW'(shift >= OffsetShift);
    elapsed  = now_ms - last_edge_time;
    fired    = elapsed >= TimeW'(wait_ms);
    rise_inc = rise_count + CountW'(1);
    fall_inc = fall_count + CountW'(1);

    last_edge_time_next = last_edge_time;
    phase_high_next     = phase_high;
    pending_delay_next  = pending_delay;
    rise_count_next     = rise_count;
    fall_count_next     = fall_count;
    clock_reg_next      = clock_reg;

    if (fired) begin
      last_edge_time_next = now_ms;
      if (!phase_high) begin
        phase_high_next    = 1'b1;
        pending_delay_next = cfg.high_phase_delay_ms;
        rise_count_next    = rise_inc;
        if (rise_inc >= target) begin
          clock_reg_next  = 1'b1;
          rise_count_next = '0;
        end
      end else begin
        phase_high_next    = 1'b0;
        pending_delay_next = cfg.low_phase_delay_ms;
        fall_count_next    = fall_inc;
        if (fall_inc >= target) begin
          clock_reg_next  = 1'b0;
          fall_count_next = '0;
        end
      end
    end

    result.gate_level  = phase_high_next;
    result.clock_level = clock_reg_next;
    result.edge_fired  = fired;

    status.phase_high = phase_high;
    status.clock_reg  = clock_reg;
    status.rise_count = rise_count;
    status.fall_count = fall_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      phase_high     <= 1'b0;
      pending_delay  <= '0;
      rise_count     <= '0;
      fall_count     <= '0;
      clock_reg      <= 1'b0;
    end else if (step) begin
      last_edge_time <= last_edge_time_next;
      phase_high     <= phase_high_next;
      pending_delay  <= pending_delay_next;
      rise_count     <= rise_count_next;
      fall_count     <= fall_count_next;
      clock_reg      <= clock_reg_next;
    end
  end

endmodule

// ===== design/divided_clock_gate_pulser.sv =====
// Divided clock gate pulser, top level: input register, step logic, result register.
// Depends on dcgp_pkg, dcgp_cfg and dcgp_step.
//
// Every timer tick request on the slave side yields exactly one result request.
// A tick is registered, evaluated against the gate wait by combinational logic, and the
// gate/clock levels land in the output register, so a new tick is taken every cycle
// while the result is not stalled; a result passes the input and then the output
// register. The rate is set by the wait compare and state update, which carries
// the gate state from one tick to the next. Configuration writes take effect at
// once and are meant to be made while no tick is in flight.
module divided_clock_gate_pulser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dcgp_pkg::TimeW-1:0]     s_tdata,   // [31:0] now_ms
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dcgp_pkg::OutW-1:0]      m_tdata,   // [0] gate_level, [1] clock_level,
                                                    // [2] edge_fired, [7:3] zero
  input  logic                           cfg_we,
  input  logic [dcgp_pkg::AddrW-1:0]     cfg_addr,
  input  logic [dcgp_pkg::MsW-1:0]       cfg_wdata
);
  import dcgp_pkg::*;

  cfg_t             cfg;
  result_t          result;
  status_t          status;
  logic             in_valid;
  logic [TimeW-1:0] in_now;
  logic             advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  dcgp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dcgp_step u_step (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .now_ms (in_now),
    .cfg    (cfg),
    .result (result),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_now <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(OutW-3){1'b0}}, result.edge_fired, result.clock_level,
                  result.gate_level};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    status.rise_count < CountW'(16) && status.fall_count < CountW'(16))
    else $error("divider counter out of range");

  a_fire_toggles: assert property (@(posedge clk) disable iff (rst)
    advance && result.edge_fired |=> m_tdata[0] != $past(status.phase_high))
    else $error("fired tick did not toggle the gate");

  a_hold_toggle: assert property (@(posedge clk) disable iff (rst)
    advance && !result.edge_fired |=> m_tdata[0] == $past(status.phase_high)
                                      && m_tdata[1] == $past(status.clock_reg))
    else $error("gate or clock changed without a fired tick");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

endmodule

// ===== test/tb_divided_clock_gate_pulser.sv =====
// Testbench for divided_clock_gate_pulser: streams timer ticks through the block and
// checks every gate/clock result against an in-bench prediction of the gate state.
// Depends on dcgp_pkg and the divided_clock_gate_pulser RTL; self-contained otherwise.
module tb_divided_clock_gate_pulser;
  timeunit 1ns;
  timeprecision 1ps;
  import dcgp_pkg::*;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [TimeW-1:0]     s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OutW-1:0]      m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [AddrW-1:0]     cfg_addr  = REG_DIVIDE_SHIFT;
  logic [MsW-1:0]       cfg_wdata = '0;

  int unsigned          send_idle_pct = 0;
  int unsigned          stall_pct     = 0;
  int                   errors        = 0;
  bit                   tick_taken    = 1'b0;
  logic [TimeW-1:0]     ticks_to_send[$];
  result_t              results_due[$];
  logic [TimeW-1:0]     clock_ms;

  // predicted gate state and register copy
  cfg_t                 cfg_copy = '{divide_shift: '0, base_period_ms: 16'd250,
                                     high_phase_delay_ms: '0, low_phase_delay_ms: '0};
  logic [TimeW-1:0]     edge_time  = '0;
  logic                 gate_hi    = 1'b0;
  logic [MsW-1:0]       duty_delay = '0;
  logic [CountW-1:0]    rises      = '0;
  logic [CountW-1:0]    falls      = '0;
  logic                 divided_hi = 1'b0;

  divided_clock_gate_pulser uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [31:0] now_ms
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [0] gate_level, [1] clock_level, [2] edge_fired, [7:3] zero
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic result_t advance_gate(logic [TimeW-1:0] now);
    logic [ShiftW-1:0] sh;
    logic [TimeW-1:0]  span;
    logic [CountW:0]   target;
    result_t           r;
    sh     = (cfg_copy.divide_shift > MaxShift) ? MaxShift : cfg_copy.divide_shift;
    target = (CountW+1)'(1) << sh;
    span   = ((TimeW'(cfg_copy.base_period_ms) + TimeW'(duty_delay)) >> sh)
             + TimeW'(sh >= OffsetShift);
    r.edge_fired = 1'b0;
    if (now - edge_time >= span) begin
      r.edge_fired = 1'b1;
      edge_time    = now;
      if (!gate_hi) begin
        gate_hi    = 1'b1;
        duty_delay = cfg_copy.high_phase_delay_ms;
        rises      = rises + 1'b1;
        if ({1'b0, rises} >= target) begin
          divided_hi = 1'b1;
          rises      = '0;
        end
      end else begin
        gate_hi    = 1'b0;
        duty_delay = cfg_copy.low_phase_delay_ms;
        falls      = falls + 1'b1;
        if ({1'b0, falls} >= target) begin
          divided_hi = 1'b0;
          falls      = '0;
        end
      end
    end
    r.gate_level  = gate_hi;
    r.clock_level = divided_hi;
    return r;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // monitor: predict on accepted ticks, compare on accepted results
  always @(posedge clk) begin
    result_t want;
    tick_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready)
      results_due.push_back(advance_gate(s_tdata));
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = results_due.pop_front();
        if (m_tdata[0] !== want.gate_level)
          report($sformatf("gate_level %b, want %b", m_tdata[0], want.gate_level));
        if (m_tdata[1] !== want.clock_level)
          report($sformatf("clock_level %b, want %b", m_tdata[1], want.clock_level));
        if (m_tdata[2] !== want.edge_fired)
          report($sformatf("edge_fired %b, want %b", m_tdata[2], want.edge_fired));
      end
    end
  end

  // driver
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || tick_taken) begin
      if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= ticks_to_send.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  task automatic settle();
    do @(posedge clk);
    while (ticks_to_send.size() != 0 || s_tvalid || results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [MsW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DIVIDE_SHIFT: cfg_copy.divide_shift        = val[ShiftW-1:0];
      REG_BASE_PERIOD:  cfg_copy.base_period_ms      = val;
      REG_HIGH_DELAY:   cfg_copy.high_phase_delay_ms = val;
      REG_LOW_DELAY:    cfg_copy.low_phase_delay_ms  = val;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [ShiftW-1:0] sh, logic [MsW-1:0] base,
                             logic [MsW-1:0] hi, logic [MsW-1:0] lo);
    write_reg(REG_DIVIDE_SHIFT, {(MsW-ShiftW)'($urandom), sh});
    write_reg(REG_BASE_PERIOD, base);
    write_reg(REG_HIGH_DELAY, hi);
    write_reg(REG_LOW_DELAY, lo);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ticks stepped by random amounts up to about 1.25 waits so the gate toggles often; some random jumps
  task automatic queue_run(int n);
    logic [ShiftW-1:0] sh;
    int unsigned       span;
    sh   = (cfg_copy.divide_shift > MaxShift) ? MaxShift : cfg_copy.divide_shift;
    span = ((cfg_copy.base_period_ms + ((cfg_copy.high_phase_delay_ms >
            cfg_copy.low_phase_delay_ms) ? cfg_copy.high_phase_delay_ms :
            cfg_copy.low_phase_delay_ms)) >> sh) + (sh >= OffsetShift);
    repeat (n) begin
      if ($urandom_range(19) == 0)
        clock_ms = $urandom;
      else
        clock_ms = clock_ms + $urandom_range(span + span / 4 + 1);
      ticks_to_send.push_back(clock_ms);
    end
  endtask

  initial begin
    logic [MsW-1:0] base, hi, lo;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: wait boundary, fall, wrap
    ticks_to_send = {32'd0, 32'd249, 32'd250, 32'd499, 32'd500, 32'hFFFF_FFFF,
                     32'd0, 32'd249, 32'h7FFF_FFFF};
    settle();
    // divider above four clamps to 4, zero period: wait of one
    load_config(3'd7, 16'd0, 16'd0, 16'd0);
    ticks_to_send = {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h8000_0002,
                     32'h8000_0003, 32'h8000_0004};
    settle();
    // divider dropped with counters past target; zero wait fires every tick
    load_config(3'd0, 16'd0, 16'd0, 16'd0);
    ticks_to_send = {32'h8000_0004, 32'h8000_0004, 32'h8000_0004, 32'h0000_0000};
    settle();
    // all-ones period and delays
    load_config(3'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    ticks_to_send = {32'd0, 32'd8191, 32'd8192, 32'd24575, 32'd24576};
    settle();

    clock_ms = 32'd24576;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 80; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      base = ($urandom_range(3) == 0) ? MsW'($urandom) : MsW'($urandom_range(400));
      hi   = ($urandom_range(3) == 0) ? MsW'($urandom) : MsW'($urandom_range(300));
      lo   = ($urandom_range(3) == 0) ? MsW'($urandom) : MsW'($urandom_range(300));
      if (p == 3)
        clock_ms = 32'hFFFF_F000;
      case (p)
        0: load_config(3'd0, 16'd1, 16'd0, 16'd0);
        1: load_config(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: load_config(ShiftW'($urandom_range(7)), base, hi, lo);
      endcase
      queue_run(60);
      settle();
    end

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
